### src/pfc_pkg.sv
// Shared types and constants for the Playfair digraph cipher.
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int SIDE      = 5;
  localparam int LETTER_W  = 5;
  localparam int ROW_W     = SIDE * LETTER_W;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [ROW_W-1:0]    key_row_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic hit_a;
    idx_t col_a;
    logic hit_b;
    idx_t col_b;
  } lane_hit_t;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam key_row_t KEY_RESET [SIDE] = '{
    25'd4294688, 25'd10755269, 25'd16201099, 25'd21613104, 25'd27025109
  };

endpackage

### src/pfc_lane.sv
// One square row: finds the first column holding each letter of the pair.
`timescale 1ns / 1ps
module pfc_lane (
  input  pfc_pkg::key_row_t  row,
  input  pfc_pkg::letter_t   letter_a,
  input  pfc_pkg::letter_t   letter_b,
  output pfc_pkg::lane_hit_t hit
);

  always_comb begin
    hit = '0;
    for (int c = pfc_pkg::SIDE - 1; c >= 0; c--) begin
      if (row[c*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] == letter_a) begin
        hit.hit_a = 1'b1;
        hit.col_a = pfc_pkg::idx_t'(c);
      end
      if (row[c*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] == letter_b) begin
        hit.hit_b = 1'b1;
        hit.col_b = pfc_pkg::idx_t'(c);
      end
    end
  end

endmodule

### src/pfc_merge.sv
// Merges the row lanes: picks first positions and applies the digraph rules.
`timescale 1ns / 1ps
module pfc_merge (
  input  pfc_pkg::lane_hit_t hits     [pfc_pkg::SIDE],
  input  pfc_pkg::key_row_t  key_rows [pfc_pkg::SIDE],
  input  logic               cmd,
  output pfc_pkg::letter_t   out_first,
  output pfc_pkg::letter_t   out_second,
  output logic               not_found
);

  function automatic pfc_pkg::idx_t idx_step(pfc_pkg::idx_t v, logic dec);
    pfc_pkg::idx_t r;
    if (dec == pfc_pkg::CMD_DECRYPT) begin
      r = (v == '0) ? pfc_pkg::idx_t'(pfc_pkg::SIDE - 1) : v - pfc_pkg::idx_t'(1);
    end else begin
      r = (v == pfc_pkg::idx_t'(pfc_pkg::SIDE - 1)) ? '0 : v + pfc_pkg::idx_t'(1);
    end
    return r;
  endfunction

  pfc_pkg::idx_t r1, c1, r2, c2;
  pfc_pkg::idx_t or1, oc1, or2, oc2;
  logic          found_a, found_b;

  always_comb begin
    r1 = '0; c1 = '0; r2 = '0; c2 = '0;
    found_a = 1'b0;
    found_b = 1'b0;
    for (int r = pfc_pkg::SIDE - 1; r >= 0; r--) begin
      if (hits[r].hit_a) begin
        found_a = 1'b1;
        r1 = pfc_pkg::idx_t'(r);
        c1 = hits[r].col_a;
      end
      if (hits[r].hit_b) begin
        found_b = 1'b1;
        r2 = pfc_pkg::idx_t'(r);
        c2 = hits[r].col_b;
      end
    end

    if (r1 == r2) begin
      or1 = r1; oc1 = idx_step(c1, cmd);
      or2 = r2; oc2 = idx_step(c2, cmd);
    end else if (c1 == c2) begin
      or1 = idx_step(r1, cmd); oc1 = c1;
      or2 = idx_step(r2, cmd); oc2 = c2;
    end else begin
      or1 = r1; oc1 = c2;
      or2 = r2; oc2 = c1;
    end

    not_found = !(found_a && found_b);
    if (not_found) begin
      out_first  = '0;
      out_second = '0;
    end else begin
      out_first  = key_rows[or1][oc1*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
      out_second = key_rows[or2][oc2*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
    end
  end

endmodule

### src/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: key square, lanes, pipeline, ports.
`timescale 1ns / 1ps
// Takes one letter pair per cycle while s_tready is high and returns it transformed, via the
// lane hit register and the output register. Five row lanes compare both letters against
// their row combinationally; a merge stage then picks the first match in row-major order and
// applies the same-row, same-column or rectangle rule into the output register. The user
// writes key rows via the config port (index 0..4) only with no word in flight; not enforced.
module playfair_digraph_cipher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pfc_pkg::TDATA_W-1:0]     s_tdata,   // first_letter[4:0], second_letter[9:5]
  input  logic                            s_tuser,   // cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pfc_pkg::TDATA_W-1:0]     m_tdata,   // out_first[4:0], out_second[9:5]
  output logic                            m_tuser,   // not_found
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  pfc_pkg::key_row_t               cfg_data
);

  pfc_pkg::key_row_t  key_row [pfc_pkg::SIDE];
  pfc_pkg::lane_hit_t lane_hit [pfc_pkg::SIDE];
  pfc_pkg::lane_hit_t s1_hit [pfc_pkg::SIDE];
  logic               s1_valid;
  logic               s1_cmd;
  pfc_pkg::letter_t   mrg_first, mrg_second;
  logic               mrg_not_found;
  pfc_pkg::letter_t   in_a, in_b;
  logic               out_free;

  assign in_a      = s_tdata[pfc_pkg::LETTER_W-1:0];
  assign in_b      = s_tdata[2*pfc_pkg::LETTER_W-1:pfc_pkg::LETTER_W];
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < pfc_pkg::SIDE; r++) key_row[r] <= pfc_pkg::KEY_RESET[r];
    end else if (cfg_valid && cfg_index < pfc_pkg::CFG_IDX_W'(pfc_pkg::SIDE)) begin
      key_row[cfg_index] <= cfg_data;
    end
  end

  for (genvar g = 0; g < pfc_pkg::SIDE; g++) begin : g_lane
    pfc_lane u_lane (
      .row      (key_row[g]),
      .letter_a (in_a),
      .letter_b (in_b),
      .hit      (lane_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_cmd <= s_tuser;
      s1_hit <= lane_hit;
    end
  end

  pfc_merge u_merge (
    .hits       (s1_hit),
    .key_rows   (key_row),
    .cmd        (s1_cmd),
    .out_first  (mrg_first),
    .out_second (mrg_second),
    .not_found  (mrg_not_found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      m_tdata <= {(pfc_pkg::TDATA_W - 2*pfc_pkg::LETTER_W)'(0), mrg_second, mrg_first};
      m_tuser <= mrg_not_found;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[2*pfc_pkg::LETTER_W-1:0] == '0))
    else $error("not_found word carries nonzero letters");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline is full");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted word lost before merge stage");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free) |=> m_tvalid)
    else $error("merge result not registered");

endmodule
